>>> rtl/mau_pkg.sv
// mau_pkg: shared types and constants for the modular arithmetic unit
// no dependencies
package mau_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 31;
  localparam logic [30:0] MODULUS_RESET   = 31'd998244353;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_INV = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_DISPATCH,
    ST_EU_DIV,
    ST_EU_UPD,
    ST_EU_FIX,
    ST_MUL,
    ST_MUL_RED,
    ST_DONE
  } state_t;

endpackage

>>> rtl/modular_arithmetic_unit.sv
// modular_arithmetic_unit: modular add/sub/mul/div/neg/inverse over a configurable modulus
// depends on mau_pkg
// every op first reduces both operands with a shared restoring divider (one quotient bit
// per cycle, W = VALUE_WIDTH); mul adds a shift-add multiply then 2W-bit reduction;
// inverse/divide add Euclid steps, each a divider pass plus an update, and divide then multiplies.
// busy stays high for the whole item, so one item at a time; out_valid pulses one cycle
// and cannot be stalled. synchronous active-low reset clears control state and sets the
// modulus to its reset value.
module modular_arithmetic_unit
  import mau_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             in_req_type,
  input  logic [VALUE_WIDTH-1:0] in_operand_a,
  input  logic [VALUE_WIDTH-1:0] in_operand_b,
  output logic                   out_valid,
  output logic [VALUE_WIDTH-1:0] out_result,
  output logic                   out_zero_divisor,
  input  logic                   cfg_we,
  input  logic [VALUE_WIDTH-1:0] cfg_modulus
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned W2 = 2 * VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W2 + 1);
  // signed coefficient width: |s| stays below the modulus
  localparam int unsigned SW = W + 2;

  state_t state_r, state_nxt;

  logic [W-1:0]  mod_r;
  logic [2:0]    op_r;
  logic [W-1:0]  a_r, b_r;
  // shared restoring divider: dividend/quotient shift register and remainder
  logic [W2-1:0] dq_r;
  logic [W:0]    rem_r;
  logic [CW-1:0] cnt_r;
  logic          div_go_r;
  // euclid registers
  logic [W-1:0]  r1_r;
  logic signed [SW-1:0] s0_r, s1_r;
  // shift-add multiplier
  logic [W2-1:0] prod_r;
  logic [W-1:0]  mcand_r, mplier_r;
  logic [CW-1:0] mul_sh_r;
  logic          flag_r;
  logic [W-1:0]  res_r;
  logic          out_valid_r;

  logic          mod_small;
  assign mod_small = (mod_r < W'(2));

  // divisor of the shared divider
  logic [W-1:0] div_den;
  assign div_den = (state_r == ST_EU_DIV) ? r1_r : mod_r;

  // one restoring divider step
  logic [W:0] trial;
  logic [W:0] rem_sh;
  assign rem_sh = {rem_r[W-1:0], dq_r[W2-1]};
  assign trial  = rem_sh - {1'b0, div_den};

  logic div_done;
  assign div_done = (cnt_r == '0) && !div_go_r;

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result       = res_r;
  assign out_zero_divisor = flag_r;

  // modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MODULUS_RESET[W-1:0];
    end else if (cfg_we) begin
      mod_r <= cfg_modulus;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath; remainder of the current division sits in rem_r
  logic [W-1:0] rem_w;
  logic [W-1:0] q_w;
  logic signed [SW+W:0] qs_prod;
  logic signed [SW-1:0] s_new;
  logic [W:0] sum_w;
  logic signed [SW-1:0] s_fix;
  assign rem_w   = rem_r[W-1:0];
  assign q_w     = dq_r[W-1:0];
  assign sum_w   = {1'b0, a_r} + {1'b0, b_r};
  // quotient times coefficient: narrow dependency, one multiply this cycle
  assign qs_prod = $signed({1'b0, q_w}) * s1_r;
  assign s_new   = s0_r - SW'(qs_prod);
  assign s_fix   = (s0_r < 0) ? s0_r + $signed({2'b00, mod_r}) : s0_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (start) state_nxt = ST_RED_A;
      ST_RED_A:    if (div_done) state_nxt = ST_RED_B;
      ST_RED_B:    if (div_done) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        if (mod_small) begin
          state_nxt = ST_DONE;
        end else begin
          case (op_r)
            OP_MUL: state_nxt = ST_MUL;
            OP_DIV: state_nxt = (b_r == '0) ? ST_MUL : ST_EU_DIV;
            OP_INV: state_nxt = (a_r == '0) ? ST_DONE : ST_EU_DIV;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_EU_DIV:   if (div_done) state_nxt = ST_EU_UPD;
      ST_EU_UPD:   state_nxt = (rem_w == '0) ? ST_EU_FIX : ST_EU_DIV;
      ST_EU_FIX:   state_nxt = (op_r == OP_DIV) ? ST_MUL : ST_DONE;
      ST_MUL:      if (mplier_r == '0) state_nxt = ST_MUL_RED;
      ST_MUL_RED:  if (div_done) state_nxt = ST_DONE;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      // divider step engine
      if (div_go_r) begin
        div_go_r <= 1'b0;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (!trial[W]) begin
          rem_r <= trial;
          dq_r  <= {dq_r[W2-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          dq_r  <= {dq_r[W2-2:0], 1'b0};
        end
      end
      case (state_r)
        ST_IDLE: if (start) begin
          op_r     <= in_req_type;
          a_r      <= in_operand_a;
          b_r      <= in_operand_b;
          flag_r   <= 1'b0;
          res_r    <= '0;
          dq_r     <= {in_operand_a, {W{1'b0}}};
          rem_r    <= '0;
          cnt_r    <= CW'(W);
          div_go_r <= 1'b1;
        end
        ST_RED_A: if (div_done) begin
          a_r      <= rem_w;
          dq_r     <= {b_r, {W{1'b0}}};
          rem_r    <= '0;
          cnt_r    <= CW'(W);
          div_go_r <= 1'b1;
        end
        ST_RED_B: if (div_done) begin
          b_r <= rem_w;
        end
        ST_DISPATCH: begin
          if (mod_small) begin
            res_r  <= '0;
            flag_r <= (op_r == OP_DIV) || (op_r == OP_INV);
          end else begin
            case (op_r)
              OP_ADD: res_r <= (sum_w >= {1'b0, mod_r}) ? W'(sum_w - {1'b0, mod_r})
                                                        : sum_w[W-1:0];
              OP_SUB: res_r <= (a_r >= b_r) ? a_r - b_r : W'(sum_w + {1'b0, mod_r}
                                - {1'b0, b_r} - {1'b0, b_r});
              OP_NEG: res_r <= (a_r == '0) ? '0 : mod_r - a_r;
              OP_MUL: begin
                prod_r   <= '0;
                mcand_r  <= a_r;
                mplier_r <= b_r;
              end
              OP_DIV: begin
                if (b_r == '0) begin
                  flag_r   <= 1'b1;
                  prod_r   <= '0;
                  mcand_r  <= a_r;
                  mplier_r <= W'(1);
                end else begin
                  r1_r <= mod_r;
                end
              end
              OP_INV: begin
                if (a_r == '0) begin
                  flag_r <= 1'b1;
                  res_r  <= W'(1);
                end else begin
                  r1_r <= mod_r;
                end
              end
              default: res_r <= '0;
            endcase
            s0_r <= SW'(1);
            s1_r <= '0;
            if ((op_r == OP_DIV && b_r != '0) || (op_r == OP_INV && a_r != '0)) begin
              dq_r     <= {{W{1'b0}}, (op_r == OP_DIV) ? b_r : a_r} << W;
              rem_r    <= '0;
              cnt_r    <= CW'(W);
              div_go_r <= 1'b1;
            end
          end
        end
        ST_EU_UPD: begin
          // r0 <- r1, r1 <- r0 mod r1, s0 <- s1, s1 <- s0 - q*s1
          r1_r <= rem_w;
          s0_r <= s1_r;
          s1_r <= s_new;
          if (rem_w != '0) begin
            dq_r     <= {r1_r, {W{1'b0}}};
            rem_r    <= '0;
            cnt_r    <= CW'(W);
            div_go_r <= 1'b1;
          end
        end
        ST_EU_FIX: begin
          if (op_r == OP_DIV) begin
            prod_r   <= '0;
            mcand_r  <= a_r;
            mplier_r <= W'(s_fix);
          end else begin
            res_r <= W'(s_fix);
          end
        end
        ST_MUL: begin
          if (mplier_r == '0) begin
            dq_r     <= prod_r;
            rem_r    <= '0;
            cnt_r    <= CW'(W2);
            div_go_r <= 1'b1;
          end else begin
            if (mplier_r[0]) prod_r <= prod_r + (W2'(mcand_r) << mul_sh_r);
            mplier_r <= mplier_r >> 1;
          end
        end
        ST_MUL_RED: if (div_done) res_r <= rem_w;
        ST_DONE: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // multiplier shift position
  always_ff @(posedge clk) begin
    if (state_r != ST_MUL) begin
      mul_sh_r <= '0;
    end else begin
      mul_sh_r <= mul_sh_r + CW'(1);
    end
  end

  // a result transfer only ever leaves the final state
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_DONE)
    else $error("result strobe outside done");
  // result stays below the modulus unless modulus is tiny
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !mod_small |-> out_result < mod_r)
    else $error("result not reduced");
  // busy falls only in the cycle of a transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without result");

endmodule
